// ===== sv/fibonacci_mod_matrix_power_defines.svh =====
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_defines.svh
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define FMMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("fmmp: property failed");

// next-cycle implication
`define FMMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("fmmp: property failed");

`endif

// ===== sv/fmmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmmp_pkg
// Types and constants shared by the Fibonacci matrix power block.
// ----------------------------------------------------------------------------
package fmmp_pkg;

  // width of the result word
  localparam int unsigned FIB_W = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_DONE
  } state_e;

  // left operand of the matrix product; right operand is always base
  typedef enum logic {
    OP_ACC,
    OP_BASE
  } opsel_e;

  typedef struct packed {
    logic   load;
    logic   mul_go;
    opsel_e mul_sel;
    logic   wr_acc;
    logic   wr_base;
    logic   shift;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic trivial;   // index is 0 or 1
    logic e_bit;     // current exponent bit
    logic e_last;    // exponent down to its top bit
    logic mul_done;  // matrix product ready
  } status_t;

endpackage

// ===== sv/fmmp_matmul.sv =====
// ----------------------------------------------------------------------------
// fmmp_matmul
// Five-stage 2x2 modular matrix product, eight lanes, Barrett reduction.
// ----------------------------------------------------------------------------
module fmmp_matmul #(
  parameter int unsigned MODULUS = 10000,
  parameter int unsigned RES_W   = $clog2(MODULUS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [RES_W-1:0] a_i [2][2],
  input  logic [RES_W-1:0] b_i [2][2],
  output logic [RES_W-1:0] r_o [2][2],
  output logic             done_o
);

  localparam int unsigned PROD_W = 2 * RES_W;
  localparam int unsigned MU_W   = RES_W + 2;
  localparam int unsigned Q2_W   = RES_W + 1 + MU_W;
  localparam int unsigned T_W    = MU_W + RES_W;
  localparam logic [63:0]         MU_FULL = (64'd1 << PROD_W) / 64'(MODULUS);
  localparam logic [MU_W-1:0]     MU      = MU_W'(MU_FULL);
  localparam logic [RES_W-1:0]    MOD_C   = RES_W'(MODULUS);
  localparam logic [MU_W-1:0]     MOD_R   = MU_W'(MODULUS);
  localparam logic [RES_W:0]      MOD_S   = (RES_W + 1)'(MODULUS);

  logic [4:0]       vld_q;
  logic [RES_W-1:0] red_w [2][2][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], go_i};
    end
  end

  assign done_o = vld_q[4];

  for (genvar gi = 0; gi < 2; gi++) begin : g_row
    for (genvar gk = 0; gk < 2; gk++) begin : g_col
      for (genvar gj = 0; gj < 2; gj++) begin : g_lane
        logic [PROD_W-1:0] prod_w;
        logic [Q2_W-1:0]   q2_w;
        logic [PROD_W-1:0] p1_q, p2_q, p3_q;
        logic [MU_W-1:0]   q_q;
        logic [T_W-1:0]    t_q;
        logic [T_W-1:0]    diff_w;
        logic [MU_W-1:0]   r0_w, r1_w, r2_w;
        logic [RES_W-1:0]  r_q;

        assign prod_w = PROD_W'(a_i[gi][gj]) * PROD_W'(b_i[gj][gk]);
        // quotient estimate, at most two short of the true one
        assign q2_w   = Q2_W'(p1_q[PROD_W-1:RES_W-1]) * Q2_W'(MU);
        assign diff_w = T_W'(p3_q) - t_q;
        assign r0_w   = diff_w[MU_W-1:0];
        assign r1_w   = (r0_w >= MOD_R) ? r0_w - MOD_R : r0_w;
        assign r2_w   = (r1_w >= MOD_R) ? r1_w - MOD_R : r1_w;

        always_ff @(posedge clk_i) begin
          p1_q <= prod_w;
          q_q  <= q2_w[Q2_W-1:RES_W+1];
          p2_q <= p1_q;
          t_q  <= T_W'(q_q) * T_W'(MOD_C);
          p3_q <= p2_q;
          r_q  <= r2_w[RES_W-1:0];
        end

        assign red_w[gi][gk][gj] = r_q;
      end

      logic [RES_W:0]   sum_w;
      logic [RES_W-1:0] ent_q;

      assign sum_w = (RES_W + 1)'(red_w[gi][gk][0]) + (RES_W + 1)'(red_w[gi][gk][1]);

      always_ff @(posedge clk_i) begin
        ent_q <= RES_W'((sum_w >= MOD_S) ? sum_w - MOD_S : sum_w);
      end

      assign r_o[gi][gk] = ent_q;
    end
  end

endmodule

// ===== sv/fmmp_datapath.sv =====
// ----------------------------------------------------------------------------
// fmmp_datapath
// Accumulator and base matrices, exponent shifter, result word register.
// ----------------------------------------------------------------------------
module fmmp_datapath #(
  parameter int unsigned MODULUS    = 10000,
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fmmp_pkg::cmd_t            cmd_i,
  output fmmp_pkg::status_t         status_o,
  input  logic [INDEX_BITS-1:0]     index_i,
  output logic [fmmp_pkg::FIB_W-1:0] fib_value_o,
  output logic                      done_o
);

  localparam int unsigned RES_W = $clog2(MODULUS + 1);

  logic [RES_W-1:0]           acc_q  [2][2];
  logic [RES_W-1:0]           base_q [2][2];
  logic [RES_W-1:0]           opa_w  [2][2];
  logic [RES_W-1:0]           prod_w [2][2];
  logic [INDEX_BITS-1:0]      e_q;
  logic                       trivial_q;
  logic                       nbit_q;
  logic [fmmp_pkg::FIB_W-1:0] out_q;
  logic                       done_q;
  logic                       mul_done_w;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 2; k++) begin
        opa_w[i][k] = (cmd_i.mul_sel == fmmp_pkg::OP_BASE) ? base_q[i][k] : acc_q[i][k];
      end
    end
  end

  fmmp_matmul #(
    .MODULUS (MODULUS),
    .RES_W   (RES_W)
  ) u_fmmp_matmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (opa_w),
    .b_i    (base_q),
    .r_o    (prod_w),
    .done_o (mul_done_w)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // identity and Q = [[1,1],[1,0]]
      acc_q[0][0]  <= RES_W'(1);
      acc_q[0][1]  <= '0;
      acc_q[1][0]  <= '0;
      acc_q[1][1]  <= RES_W'(1);
      base_q[0][0] <= RES_W'(1);
      base_q[0][1] <= RES_W'(1);
      base_q[1][0] <= RES_W'(1);
      base_q[1][1] <= '0;
      e_q          <= index_i - INDEX_BITS'(1);
      trivial_q    <= ((index_i >> 1) == '0);
      nbit_q       <= index_i[0];
    end else begin
      if (cmd_i.wr_acc) begin
        acc_q <= prod_w;
      end
      if (cmd_i.wr_base) begin
        base_q <= prod_w;
      end
      if (cmd_i.shift) begin
        e_q <= e_q >> 1;
      end
    end
    if (cmd_i.finish) begin
      out_q <= trivial_q ? fmmp_pkg::FIB_W'(nbit_q) : fmmp_pkg::FIB_W'(acc_q[0][0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign status_o.trivial  = trivial_q;
  assign status_o.e_bit    = e_q[0];
  assign status_o.e_last   = ((e_q >> 1) == '0);
  assign status_o.mul_done = mul_done_w;

  assign fib_value_o = out_q;
  assign done_o      = done_q;

endmodule

// ===== sv/fmmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmmp_ctrl
// Sequencer for square-and-multiply over the exponent bits, LSB first.
// ----------------------------------------------------------------------------
module fmmp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fmmp_pkg::status_t status_i,
  output fmmp_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  fmmp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmmp_pkg::ST_IDLE: begin
        if (start_i) state_d = fmmp_pkg::ST_CHECK;
      end
      fmmp_pkg::ST_CHECK: begin
        if (status_i.trivial)    state_d = fmmp_pkg::ST_DONE;
        else if (status_i.e_bit) state_d = fmmp_pkg::ST_WAIT_A;
        else                     state_d = fmmp_pkg::ST_WAIT_B;
      end
      fmmp_pkg::ST_WAIT_A: begin
        if (status_i.mul_done) begin
          state_d = status_i.e_last ? fmmp_pkg::ST_DONE : fmmp_pkg::ST_WAIT_B;
        end
      end
      fmmp_pkg::ST_WAIT_B: begin
        if (status_i.mul_done) state_d = fmmp_pkg::ST_CHECK;
      end
      fmmp_pkg::ST_DONE: begin
        state_d = fmmp_pkg::ST_IDLE;
      end
      default: state_d = fmmp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = fmmp_pkg::OP_BASE;
    busy_o        = 1'b1;
    unique case (state_q)
      fmmp_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      fmmp_pkg::ST_CHECK: begin
        if (!status_i.trivial) begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = status_i.e_bit ? fmmp_pkg::OP_ACC : fmmp_pkg::OP_BASE;
        end
      end
      fmmp_pkg::ST_WAIT_A: begin
        if (status_i.mul_done) begin
          cmd_o.wr_acc = 1'b1;
          // square base straight away; it does not read acc
          cmd_o.mul_go = !status_i.e_last;
        end
      end
      fmmp_pkg::ST_WAIT_B: begin
        if (status_i.mul_done) begin
          cmd_o.wr_base = 1'b1;
          cmd_o.shift   = 1'b1;
        end
      end
      fmmp_pkg::ST_DONE: begin
        cmd_o.finish = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// ===== sv/fibonacci_mod_matrix_power.sv =====
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power
// F(n) mod MODULUS by 2x2 matrix square-and-multiply, one word in, one out.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  --------  -------------------------  -----------------------------------
//  in word   index_i                    taken when start && !busy
//  out word  fib_value_o                valid from done_o until next result
//
// Index 0 or 1: the check state goes straight to done, skipping the matrix unit.
// Otherwise every product runs through the five-stage matrix unit, used at
// most twice per bit of n-1: a clear bit squares the base, a set bit first
// multiplies into the accumulator, the top bit ending after its multiply;
// the worst case is n = 2^31 - 1 at 31 bits.
// busy stays high from the accepting edge until the result cycle.
// The receiver cannot stall; reset is asynchronous, clearing the sequencer.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power #(
  parameter int unsigned MODULUS    = 10000,
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [INDEX_BITS-1:0]      index_i,
  output logic [fmmp_pkg::FIB_W-1:0] fib_value_o,
  output logic                       done_o
);

  // command and status between sequencer and datapath
  fmmp_pkg::cmd_t    cmd_w;
  fmmp_pkg::status_t status_w;

  fmmp_ctrl u_fmmp_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status_w),
    .cmd_o    (cmd_w),
    .busy_o   (busy)
  );

  // matrices, exponent and the result word register
  fmmp_datapath #(
    .MODULUS    (MODULUS),
    .INDEX_BITS (INDEX_BITS)
  ) u_fmmp_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_w),
    .status_o    (status_w),
    .index_i     (index_i),
    .fib_value_o (fib_value_o),
    .done_o      (done_o)
  );

endmodule

// ===== sv/fmmp_checker.sv =====
// ----------------------------------------------------------------------------
// fmmp_checker
// Port-level checks on the Fibonacci matrix power block, bound to the top.
// ----------------------------------------------------------------------------
`include "fibonacci_mod_matrix_power_defines.svh"

module fmmp_checker #(
  parameter int unsigned MODULUS    = 10000,
  parameter int unsigned INDEX_BITS = 31
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [INDEX_BITS-1:0]      index_i,
  input logic [fmmp_pkg::FIB_W-1:0] fib_value_o,
  input logic                       done_o
);

  // an accepted word keeps the block busy
  `FMMP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // result cycle is already free for the next word
  `FMMP_ASSERT_NOW(a_done_not_busy, done_o, !busy)

  // one strobe per word
  `FMMP_ASSERT_NEXT(a_done_single, done_o, !done_o)

  // index 0 or 1 answers with itself
  `FMMP_ASSERT_NOW(a_trivial_index, start && !busy && ((index_i >> 1) == '0),
                   ##3 (done_o && (fib_value_o == $past(index_i, 3))))

endmodule

bind fibonacci_mod_matrix_power fmmp_checker #(
  .MODULUS    (MODULUS),
  .INDEX_BITS (INDEX_BITS)
) u_fmmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .index_i     (index_i),
  .fib_value_o (fib_value_o),
  .done_o      (done_o)
);
